@@ rtl/core/bds_pkg.sv @@
// Shared constants for the 2x2 box downsample block.
package bds_pkg;

  // Default sizing of the top level
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  // Configuration port
  localparam int CFG_W      = 13;
  localparam int CFG_ADDR_W = 1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Size registers after reset, before clamping
  localparam int SIZE_RST = 512;

endpackage

@@ rtl/core/bds_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bds_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/box_downsample_2x2_unit.sv @@
// Top level of the 2x2 box downsample (half-size mipmap level) block.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata: pixel_value
//  out_    | out | out_tvalid / out_tready| out_tdata: block_average, tlast: frame_last
//  cfg_    | in  | cfg_we                 | cfg_addr, cfg_wdata
//
// One pixel per cycle sustained while the output is not stalled. A pixel's result
// passes the line store read in stage 1, then the final add into the output register.
// The line store allows one access per pixel, which sets the rate.
// Reset clears the counters and the pipeline valids; the line store needs no clearing.
// A stalled output holds the output register, and the line read stage once it is
// full; input keeps flowing while either stage has room.
module box_downsample_2x2_unit
  import bds_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic clk,
  input  logic rst_n,
  // pixel_value [PIXEL_BITS-1:0], zero padded to bytes
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // block_average [PIXEL_BITS+1:0], zero padded to bytes
  output logic [((PIXEL_BITS+2+7)/8)*8-1:0]   out_tdata,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [CFG_W-1:0]                    cfg_wdata
);

  localparam int PW     = PIXEL_BITS;
  localparam int SW     = PW + 2;
  localparam int LD     = MAX_WIDTH / 2;
  localparam int AW     = $clog2(LD);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int XW     = EW + 1;
  localparam int KW     = (CFG_W > XW) ? CFG_W : XW;
  localparam int OUT_TW = ((SW + 7) / 8) * 8;
  localparam int RST_EFF = (SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : SIZE_RST;

  // clamp a size register to 2..MAX_WIDTH
  function automatic logic [EW-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [KW-1:0] ve;
    ve = KW'(v);
    if (ve < KW'(2)) begin
      return EW'(2);
    end else if (ve > KW'(MAX_WIDTH)) begin
      return EW'(MAX_WIDTH);
    end else begin
      return EW'(ve);
    end
  endfunction

  logic [EW-1:0]  width_r, height_r;
  logic [CW-1:0]  col_r, col_nxt;
  logic [CW-1:0]  row_r, row_nxt;
  logic [PW-1:0]  hold_r, hold_nxt;
  logic           s1_vld_r, s1_last_r;
  logic [PW:0]    s1_psum_r;
  logic           out_vld_r, out_last_r;
  logic [SW-1:0]  out_sum_r;

  logic           in_fire, out_adv;
  logic [PW-1:0]  pix;
  logic [PW:0]    pair_sum;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_addr;
  logic [PW:0]    ram_rdata;
  logic [EW-1:0]  last_col, last_row;
  logic           at_last;
  logic [XW-1:0]  col_inc, row_inc;

  // size registers, kept in clamped form
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= EW'(RST_EFF);
      height_r <= EW'(RST_EFF);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= eff_size(cfg_wdata);
        REG_IMAGE_HEIGHT: height_r <= eff_size(cfg_wdata);
        default: ;
      endcase
    end
  end

  // handshake
  assign out_adv   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;

  // pair arithmetic and line store access
  assign pix      = in_tdata[PW-1:0];
  assign pair_sum = {1'b0, hold_r} + {1'b0, pix};
  assign ram_addr = col_r[AW:1];
  assign ram_we   = in_fire && col_r[0] && !row_r[0];
  assign ram_re   = in_fire && col_r[0] && row_r[0];

  // last output position of the frame
  assign last_col = {width_r[EW-1:1], 1'b0} - EW'(1);
  assign last_row = {height_r[EW-1:1], 1'b0} - EW'(1);
  assign at_last  = (EW'(col_r) == last_col) && (EW'(row_r) == last_row);

  // raster counters and pair hold
  always_comb begin
    col_inc  = XW'(col_r) + XW'(1);
    row_inc  = XW'(row_r) + XW'(1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    hold_nxt = hold_r;
    if (in_fire) begin
      if (!col_r[0]) begin
        hold_nxt = pix;
      end
      if (col_inc >= XW'(width_r)) begin
        col_nxt = '0;
        if (row_inc >= XW'(height_r)) begin
          row_nxt = '0;
        end else begin
          row_nxt = CW'(row_inc);
        end
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hold_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      hold_r <= hold_nxt;
    end
  end

  // line store of even-row pair sums
  bds_ram #(
    .WIDTH (PW + 1),
    .DEPTH (LD)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (pair_sum),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // stage 1: waits for the line store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_psum_r <= pair_sum;
      s1_last_r <= at_last;
    end
  end

  // output register: four-pixel sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_sum_r  <= SW'(ram_rdata) + SW'(s1_psum_r);
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'(out_sum_r);
  assign out_tlast  = out_last_r;

  // never accept into a stage that is full and stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && s1_vld_r && !out_adv))
    else $error("pixel accepted over a held stage 1 entry");

  // a held stage 1 result is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_adv) |=> s1_vld_r)
    else $error("stage 1 result dropped under stall");

  // one line store access per pixel
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store read and write in one cycle");

endmodule

@@ bench/box_downsample_2x2_unit_tb.sv @@
// Self-checking testbench for the 2x2 box downsample unit: random pixel streams against a local line-store model.
`timescale 1ns / 1ps

module box_downsample_2x2_unit_tb;
  import bds_pkg::*;

  localparam int LINE_ENTRIES  = DEF_MAX_WIDTH / 2;
  localparam int RANDOM_PIXELS = 1550;
  localparam int EDGE_PIXELS   = 64;

  typedef struct packed {
    logic [17:0] average;
    logic        frame_end;
  } block_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  // pixel_value [15:0]
  logic [15:0]           in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // block_average [17:0], zero padding above
  logic [23:0]           out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  box_downsample_2x2_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Local copy of the block state and its size registers
  logic [CFG_W-1:0] width_reg  = CFG_W'(SIZE_RST);
  logic [CFG_W-1:0] height_reg = CFG_W'(SIZE_RST);
  int               col_pos    = 0;
  int               row_pos    = 0;
  logic [15:0]      hold_pix   = '0;
  logic [16:0]      pair_line [LINE_ENTRIES];
  bit               line_written [LINE_ENTRIES];

  logic [15:0]      pixel_queue [$];
  block_result_t    block_results [$];
  block_result_t    front_block;

  int mismatch_count = 0;
  int in_idle_max    = 4;
  int out_stall_max  = 4;
  int in_hold        = 0;
  int out_hold       = 0;
  int out_draw;

  function automatic int clamp_size(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic void flag_error(string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endfunction

  // Advance the model by one pixel; an odd row at an odd column yields a block sum
  task automatic fold_pixel(logic [15:0] pix);
    int            w;
    int            h;
    int            idx;
    block_result_t res;
    w   = clamp_size(width_reg);
    h   = clamp_size(height_reg);
    idx = col_pos / 2;
    if (col_pos % 2 == 0) begin
      hold_pix = pix;
    end else if (row_pos % 2 == 0) begin
      pair_line[idx]    = hold_pix + pix;
      line_written[idx] = 1'b1;
    end else begin
      res.average   = {1'b0, pair_line[idx]} + hold_pix + pix;
      res.frame_end = (col_pos == (w & ~1) - 1) && (row_pos == (h & ~1) - 1);
      block_results.push_back(res);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // A width change must not make the rest of an odd row read a line entry never written
  function automatic bit width_change_safe(logic [CFG_W-1:0] v);
    int last_col;
    if (row_pos % 2 == 0) return 1'b1;
    last_col = clamp_size(v) - 1;
    if (col_pos > last_col) last_col = col_pos;
    for (int c = col_pos; c <= last_col; c++)
      if (c % 2 == 1 && !line_written[c / 2]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pixels_to_frame_end();
    int w;
    int h;
    int n;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    n = (col_pos >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) n += (h - row_pos - 1) * w;
    return n;
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 3;
      4, 5, 6: return CFG_W'($urandom_range(25, 64));
      default: return CFG_W'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pixels(int n);
    repeat (n) pixel_queue.push_back(rand_pixel());
  endtask

  // Some phases run with no idling on one or both sides
  task automatic pick_pace();
    in_idle_max   = ($urandom_range(0, 3) == 0) ? 0 : 4;
    out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = v;
      REG_IMAGE_HEIGHT: height_reg = v;
      default: ;
    endcase
  endtask

  // Block is idle once every pixel went in and every block sum came out
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pixel_queue.size() != 0 || in_tvalid || block_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Pixel driver: random gap after each accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_hold   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_hold != 0) begin
        in_tvalid <= 1'b0;
        in_hold   <= in_hold - 1;
      end else if (pixel_queue.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pixel_queue.pop_front();
        in_hold   <= $urandom_range(0, in_idle_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random stall after each accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold   <= 0;
    end else if (out_tvalid && out_tready) begin
      out_draw = $urandom_range(0, out_stall_max);
      out_tready <= (out_draw == 0);
      out_hold   <= out_draw;
    end else if (out_hold != 0) begin
      out_hold   <= out_hold - 1;
      out_tready <= (out_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: check results in order, then feed accepted pixels to the model
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (block_results.size() == 0) begin
          flag_error($sformatf("unexpected block sum %0d last %0b", out_tdata[17:0], out_tlast));
        end else begin
          front_block = block_results.pop_front();
          if (out_tdata[17:0] !== front_block.average || out_tlast !== front_block.frame_end)
            flag_error($sformatf("block sum mismatch: expected %0d last %0b, got %0d last %0b",
                                 front_block.average, front_block.frame_end,
                                 out_tdata[17:0], out_tlast));
        end
      end
      if (in_tvalid && in_tready) fold_pixel(in_tdata);
    end
  end

  // Stimulus
  initial begin
    int               random_sent;
    int               n;
    logic [CFG_W-1:0] v;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3: trailing column and row dropped, one full-scale block ending the frame
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    pixel_queue = '{16'hFFFF, 16'hFFFF, 16'h04D2, 16'hFFFF, 16'hFFFF, 16'h10E1,
                    16'h0007, 16'h0008, 16'h0009};
    wait_idle();

    // 4x2 frame of zeros and alternating bits, then stop mid-frame
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 2);
    pixel_queue = '{16'h0000, 16'h0000, 16'hAAAA, 16'h5555,
                    16'h0000, 16'h0000, 16'h5555, 16'hAAAA,
                    16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h1234, 16'h4321};
    wait_idle();

    // shrink width under a column counter already past the new row end,
    // then run on to the start of a frame
    write_reg(REG_IMAGE_WIDTH, 2);
    queue_pixels(5);
    wait_idle();

    // start of the widest row (over-range value clamps) with too-small height
    pick_pace();
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 0);
    queue_pixels(EDGE_PIXELS);
    wait_idle();

    // start of the tallest frame with too-small width
    pick_pace();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 13'd4096);
    queue_pixels(EDGE_PIXELS);
    wait_idle();

    // random phases: mostly whole frames, some cut short or arbitrary
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      pick_pace();
      if ($urandom_range(0, 3) != 0) begin
        v = pick_size();
        if (width_change_safe(v)) write_reg(REG_IMAGE_WIDTH, v);
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, pick_size());
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          n = pixels_to_frame_end()
              + $urandom_range(0, 2) * clamp_size(width_reg) * clamp_size(height_reg);
        6, 7, 8: n = $urandom_range(1, pixels_to_frame_end());
        default: n = $urandom_range(1, 40);
      endcase
      // keep the total pixel count near the budget
      if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;
      queue_pixels(n);
      random_sent += n;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (block_results.size() != 0)
      flag_error($sformatf("%0d block sums never arrived", block_results.size()));
    if (mismatch_count == 0) begin
      $display("box_downsample_2x2_unit verification clean");
    end else begin
      $display("box_downsample_2x2_unit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("box_downsample_2x2_unit verification failed");
    $finish;
  end

endmodule
